// ===== hdl/obu_tus_pkg.sv =====
// Package for the OBU temporal unit splitter: phase codes, OBU type codes,
// record and byte payload structs, and the FIFO push bundle.
// No dependencies.
package obu_tus_pkg;

	localparam int OFFSET_BITS    = 32;
	localparam int UNIT_LIMIT_MAX = 4096;
	localparam int LIMIT_CMP_W    = 17;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [12:0] UNIT_LIMIT_RESET = 13'd4096;
	localparam logic [12:0] UNIT_CNT_SAT     = 13'h1fff;
	localparam logic [15:0] CNT16_SAT        = 16'hffff;
	localparam logic [2:0]  SIZE_IDX_LAST    = 3'd7;

	localparam logic [3:0] TY_SEQ_HDR   = 4'd1;
	localparam logic [3:0] TY_TD        = 4'd2;
	localparam logic [3:0] TY_FRAME_HDR = 4'd3;
	localparam logic [3:0] TY_FRAME     = 4'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_SIZE   = 3'd1;
	localparam logic [2:0] ST_BAD_LEB   = 3'd2;
	localparam logic [2:0] ST_OVERRUN   = 3'd3;
	localparam logic [2:0] ST_LIMIT     = 3'd4;

	localparam logic KIND_UNIT    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_EXT,
		PH_LEB,
		PH_PAYLOAD,
		PH_HALT
	} phase_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       final_byte;
	} obu_byte_t;

	typedef struct packed {
		logic        record_kind;
		logic [31:0] unit_offset;
		logic [31:0] unit_bytes;
		logic [15:0] unit_frames;
		logic [12:0] units_seen;
		logic [15:0] seq_header_total;
		logic [2:0]  status;
		logic        run_end;
	} obu_rec_t;

	typedef struct packed {
		logic     v0;
		logic     v1;
		obu_rec_t r0;
		obu_rec_t r1;
	} rec_push_t;

endpackage

// ===== hdl/obu_tus_parser.sv =====
// OBU stream parser: header, extension skip, LEB128 size, payload skip and
// temporal unit bookkeeping, one byte per cycle while accept is high.
// Produces up to two records. Depends on obu_tus_pkg.
module obu_tus_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  obu_tus_pkg::obu_byte_t byte_data,
	input  logic                  cfg_wr_en,
	input  logic [12:0]           cfg_wr_data,
	output obu_tus_pkg::rec_push_t push
);

	localparam int PW = obu_tus_pkg::OFFSET_BITS;
	localparam int LIMIT_CMP_W_L = obu_tus_pkg::LIMIT_CMP_W;

	obu_tus_pkg::phase_t phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [PW-1:0] uoff_q, uoff_d;
	logic [3:0]    type_q, type_d;
	logic [63:0]   acc_q, acc_d;
	logic [2:0]    idx_q, idx_d;
	logic [63:0]   left_q, left_d;
	logic [15:0]   frames_q, frames_d;
	logic [12:0]   units_q, units_d;
	logic [15:0]   seqs_q, seqs_d;
	logic [2:0]    halt_q, halt_d;
	logic [12:0]   limit_q;

	logic [7:0]  b;
	logic [63:0] acc_new;
	logic [63:0] left_dec;
	logic [LIMIT_CMP_W_L-1:0] lim_eff;
	logic        complete;
	logic [2:0]  end_status;
	logic        mid_v, end_unit_v;
	obu_tus_pkg::obu_rec_t rec_mid, rec_end, rec_sum;

	assign b        = byte_data.stream_byte;
	assign acc_new  = acc_q | (64'(b[6:0]) << (6'(idx_q) * 6'd7));
	assign left_dec = left_q - 64'd1;

	always_comb begin
		if ({4'd0, limit_q} > LIMIT_CMP_W_L'(obu_tus_pkg::UNIT_LIMIT_MAX))
			lim_eff = LIMIT_CMP_W_L'(obu_tus_pkg::UNIT_LIMIT_MAX);
		else
			lim_eff = {4'd0, limit_q};
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		uoff_d   = uoff_q;
		type_d   = type_q;
		acc_d    = acc_q;
		idx_d    = idx_q;
		left_d   = left_q;
		frames_d = frames_q;
		units_d  = units_q;
		seqs_d   = seqs_q;
		halt_d   = halt_q;
		complete = 1'b0;
		mid_v    = 1'b0;

		rec_mid                  = '0;
		rec_mid.record_kind      = obu_tus_pkg::KIND_UNIT;
		rec_mid.unit_offset      = 32'(uoff_q);
		rec_mid.unit_bytes       = 32'(PW'(pos_q - uoff_q));
		rec_mid.unit_frames      = frames_q;
		rec_mid.units_seen       = units_q;
		rec_mid.seq_header_total = seqs_q;
		rec_mid.status           = obu_tus_pkg::ST_OK;
		rec_mid.run_end          = ~byte_data.final_byte;

		case (phase_q)
			obu_tus_pkg::PH_HEADER: begin
				if (!b[1]) begin
					halt_d  = obu_tus_pkg::ST_NO_SIZE;
					phase_d = obu_tus_pkg::PH_HALT;
				end else begin
					if (b[6:3] == obu_tus_pkg::TY_TD) begin
						mid_v    = units_q != 13'd0;
						uoff_d   = pos_q;
						frames_d = 16'd0;
					end
					type_d  = b[6:3];
					acc_d   = 64'd0;
					idx_d   = 3'd0;
					phase_d = b[2] ? obu_tus_pkg::PH_EXT : obu_tus_pkg::PH_LEB;
				end
			end
			obu_tus_pkg::PH_EXT: phase_d = obu_tus_pkg::PH_LEB;
			obu_tus_pkg::PH_LEB: begin
				acc_d = acc_new;
				if (b[7]) begin
					if (idx_q == obu_tus_pkg::SIZE_IDX_LAST) begin
						halt_d  = obu_tus_pkg::ST_BAD_LEB;
						phase_d = obu_tus_pkg::PH_HALT;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end else begin
					left_d = acc_new;
					if (acc_new == 64'd0)
						complete = 1'b1;
					else
						phase_d = obu_tus_pkg::PH_PAYLOAD;
				end
			end
			obu_tus_pkg::PH_PAYLOAD: begin
				left_d = left_dec;
				complete = left_dec == 64'd0;
			end
			default: ;
		endcase

		// OBU counted on its last byte
		if (complete) begin
			phase_d = obu_tus_pkg::PH_HEADER;
			if (type_q == obu_tus_pkg::TY_TD) begin
				if ({4'd0, units_q} >= lim_eff) begin
					halt_d  = obu_tus_pkg::ST_LIMIT;
					phase_d = obu_tus_pkg::PH_HALT;
				end else if (units_q != obu_tus_pkg::UNIT_CNT_SAT) begin
					units_d = units_q + 13'd1;
				end
			end
			if ((type_q == obu_tus_pkg::TY_FRAME || type_q == obu_tus_pkg::TY_FRAME_HDR)
					&& units_q != 13'd0 && frames_q != obu_tus_pkg::CNT16_SAT)
				frames_d = frames_q + 16'd1;
			if (type_q == obu_tus_pkg::TY_SEQ_HDR && seqs_q != obu_tus_pkg::CNT16_SAT)
				seqs_d = seqs_q + 16'd1;
		end

		case (phase_d)
			obu_tus_pkg::PH_HALT:   end_status = halt_d;
			obu_tus_pkg::PH_HEADER: end_status = obu_tus_pkg::ST_OK;
			obu_tus_pkg::PH_LEB:    end_status = obu_tus_pkg::ST_BAD_LEB;
			default:                end_status = obu_tus_pkg::ST_OVERRUN;
		endcase

		end_unit_v = byte_data.final_byte && end_status == obu_tus_pkg::ST_OK
			&& units_d != 13'd0;

		rec_end                  = '0;
		rec_end.record_kind      = obu_tus_pkg::KIND_UNIT;
		rec_end.unit_offset      = 32'(uoff_d);
		rec_end.unit_bytes       = 32'(PW'(pos_q + PW'(1) - uoff_d));
		rec_end.unit_frames      = frames_d;
		rec_end.units_seen       = units_d;
		rec_end.seq_header_total = seqs_d;
		rec_end.status           = obu_tus_pkg::ST_OK;
		rec_end.run_end          = 1'b0;

		rec_sum                  = '0;
		rec_sum.record_kind      = obu_tus_pkg::KIND_SUMMARY;
		rec_sum.units_seen       = units_d;
		rec_sum.seq_header_total = seqs_d;
		rec_sum.status           = end_status;
		rec_sum.run_end          = 1'b1;

		// stream end: everything but the limit register back to reset
		if (byte_data.final_byte) begin
			phase_d  = obu_tus_pkg::PH_HEADER;
			pos_d    = '0;
			uoff_d   = '0;
			type_d   = 4'd0;
			acc_d    = 64'd0;
			idx_d    = 3'd0;
			left_d   = 64'd0;
			frames_d = 16'd0;
			units_d  = 13'd0;
			seqs_d   = 16'd0;
			halt_d   = obu_tus_pkg::ST_OK;
		end else begin
			pos_d = pos_q + PW'(1);
		end
	end

	// a mid-stream record and an end-of-stream unit record never coincide
	always_comb begin
		push.v0 = accept && (mid_v || byte_data.final_byte);
		push.v1 = accept && byte_data.final_byte && (mid_v || end_unit_v);
		push.r0 = mid_v ? rec_mid : (end_unit_v ? rec_end : rec_sum);
		push.r1 = rec_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= obu_tus_pkg::PH_HEADER;
			pos_q    <= '0;
			uoff_q   <= '0;
			type_q   <= 4'd0;
			acc_q    <= 64'd0;
			idx_q    <= 3'd0;
			left_q   <= 64'd0;
			frames_q <= 16'd0;
			units_q  <= 13'd0;
			seqs_q   <= 16'd0;
			halt_q   <= obu_tus_pkg::ST_OK;
		end else if (accept) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			uoff_q   <= uoff_d;
			type_q   <= type_d;
			acc_q    <= acc_d;
			idx_q    <= idx_d;
			left_q   <= left_d;
			frames_q <= frames_d;
			units_q  <= units_d;
			seqs_q   <= seqs_d;
			halt_q   <= halt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= obu_tus_pkg::UNIT_LIMIT_RESET;
		else if (cfg_wr_en)
			limit_q <= cfg_wr_data;
	end

endmodule

// ===== hdl/obu_tus_fifo.sv =====
// Output record queue: takes up to two records per cycle, hands out one.
// Raises full_for_two when fewer than two slots may be free.
// Depends on obu_tus_pkg.
module obu_tus_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  obu_tus_pkg::rec_push_t push,
	output logic                   full_for_two,
	output logic                   rec_valid,
	input  logic                   rec_stall,
	output obu_tus_pkg::obu_rec_t  rec_data
);

	localparam int PTRW = obu_tus_pkg::FIFO_PTR_W;
	localparam int CNTW = obu_tus_pkg::FIFO_CNT_W;

	obu_tus_pkg::obu_rec_t mem_q [obu_tus_pkg::FIFO_DEPTH];
	logic [PTRW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;
	logic            pop;
	logic [CNTW-1:0] n_push;

	assign pop          = rec_valid && !rec_stall;
	assign n_push       = CNTW'(push.v0) + CNTW'(push.v1);
	assign rec_valid    = cnt_q != '0;
	assign rec_data     = mem_q[rd_q];
	assign full_for_two = cnt_q > CNTW'(obu_tus_pkg::FIFO_DEPTH - 2);

	// v1 is only ever set together with v0
	always_ff @(posedge clk) begin
		if (push.v0)
			mem_q[wr_q] <= push.r0;
		if (push.v1)
			mem_q[wr_q + PTRW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTRW'(n_push);
			if (pop)
				rd_q <= rd_q + PTRW'(1);
			cnt_q <= cnt_q + n_push - CNTW'(pop);
		end
	end

endmodule

// ===== hdl/obu_temporal_unit_splitter.sv =====
// Top level of the OBU temporal unit splitter: parser plus output queue.
// Depends on obu_tus_pkg, obu_tus_parser and obu_tus_fifo.
//
// Usage:
//   byte channel (byte_valid/byte_stall/byte_data) carries one stream byte per
//   transfer; final_byte marks the last byte of a stream.
//   rec channel (rec_valid/rec_stall/rec_data) carries unit records and the
//   end-of-stream summary; run_end marks the last record caused by a byte.
//   cfg_wr_en/cfg_wr_data write unit_limit; write only while idle.
// Throughput: one byte per cycle while byte_stall is low. A byte is parsed in
//   the cycle it is taken, and its records enter the queue the cycle after.
// A byte yields at most two records; the four-entry output queue drains one
//   per cycle, and byte_stall rises while fewer than two slots may be free.
//   A receiver that stalls simply fills the queue and then holds off bytes.
// Reset clears the parser to the start of a stream at offset 0, empties the
//   queue and sets unit_limit to 4096. After each final byte the parser
//   returns to that start state on its own.
module obu_temporal_unit_splitter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  obu_tus_pkg::obu_byte_t byte_data,
	output logic                   rec_valid,
	input  logic                   rec_stall,
	output obu_tus_pkg::obu_rec_t  rec_data,
	input  logic                   cfg_wr_en,
	input  logic [12:0]            cfg_wr_data
);

	obu_tus_pkg::rec_push_t push;
	logic accept;

	assign accept = byte_valid && !byte_stall;

	obu_tus_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.byte_data   (byte_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push)
	);

	obu_tus_fifo u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full_for_two (byte_stall),
		.rec_valid    (rec_valid),
		.rec_stall    (rec_stall),
		.rec_data     (rec_data)
	);

endmodule
